/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/ucb1_pkg.sv */
// ----------------------------------------------------------------------------
// ucb1_pkg
// Request codes, register indexes and shared types of the UCB1 arm selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ucb1_pkg;

    localparam logic [1:0] REQ_SELECT = 2'd0;
    localparam logic [1:0] REQ_RECORD = 2'd1;
    localparam logic [1:0] REQ_LOAD   = 2'd2;
    localparam logic [1:0] REQ_NOP    = 2'd3;

    localparam int          CFG_IDX_W     = 2;
    localparam logic [1:0]  CFG_ARM_COUNT = 2'd0;
    localparam logic [1:0]  CFG_EXPLORE   = 2'd1;

    localparam logic [16:0] EXPLORE_RESET = 17'd45875;
    localparam logic [15:0] LN2_Q16       = 16'd45426;

    typedef struct packed {
        logic start;
        logic sqrt_op;
    } unit_ctl_t;

endpackage

/* hw/rtl/ucb1_iter_unit.sv */
// ----------------------------------------------------------------------------
// ucb1_iter_unit
// Shared iterative unit: restoring division one bit per cycle, or exact
// integer square root one bit pair per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucb1_iter_unit #(
    parameter int DW = 37,
    parameter int VW = 17,
    parameter int SW = 54
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ucb1_pkg::unit_ctl_t ctl,
    input  logic [SW-1:0]       a_in,
    input  logic [VW-1:0]       b_in,
    output logic                done,
    output logic [DW-1:0]       quo,
    output logic [SW/2-1:0]     root
);

    localparam int RTW = SW / 2;
    localparam int SRW = RTW + 1;
    localparam int CW  = $clog2(DW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic            op_reg, op_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [SW-1:0]   x_reg, x_next;
    logic [VW-1:0]   d_reg, d_next;
    logic [VW-1:0]   dr_reg, dr_next;
    logic [SRW-1:0]  sr_reg, sr_next;
    logic [RTW-1:0]  root_reg, root_next;

    logic [VW:0]     div_r, div_sub;
    logic            div_ge;
    logic [SRW+1:0]  sq_r, sq_t, sq_sub;
    logic            sq_ge;

    always_comb begin
        div_r   = {dr_reg, x_reg[DW-1]};
        div_ge  = div_r >= {1'b0, d_reg};
        div_sub = div_r - {1'b0, d_reg};
        sq_r    = {sr_reg, x_reg[SW-1:SW-2]};
        sq_t    = (SRW+2)'({root_reg, 2'b01});
        sq_ge   = sq_r >= sq_t;
        sq_sub  = sq_r - sq_t;

        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        d_next    = d_reg;
        dr_next   = dr_reg;
        sr_next   = sr_reg;
        root_next = root_reg;

        if (ctl.start) begin
            busy_next = 1'b1;
            op_next   = ctl.sqrt_op;
            cnt_next  = ctl.sqrt_op ? CW'(RTW) : CW'(DW);
            x_next    = a_in;
            d_next    = b_in;
            dr_next   = '0;
            sr_next   = '0;
            root_next = '0;
        end else if (busy_reg) begin
            if (op_reg) begin
                x_next    = {x_reg[SW-3:0], 2'b00};
                sr_next   = sq_ge ? sq_sub[SRW-1:0] : sq_r[SRW-1:0];
                root_next = {root_reg[RTW-2:0], sq_ge};
            end else begin
                x_next  = {x_reg[SW-1:DW], x_reg[DW-2:0], div_ge};
                dr_next = div_ge ? div_sub[VW-1:0] : div_r[VW-1:0];
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        d_reg    <= d_next;
        dr_reg   <= dr_next;
        sr_reg   <= sr_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign quo  = x_reg[DW-1:0];
    assign root = root_reg;

endmodule

/* hw/rtl/ucb1_arm_selector_top.sv */
// ----------------------------------------------------------------------------
// ucb1_arm_selector_top
// UCB1 bandit arm selector with per-arm win and loss counters in memory.
// ----------------------------------------------------------------------------
// One request is worked at a time. No-op, load and a select with no usable
// arms go straight to the result register; a record reads the arm's counters,
// modifies them and writes them back. A select reads every usable arm once;
// if one is untried it ends there. Otherwise it normalizes the total, runs 16
// log squarings, and then for each arm computes the mean, the ratio and the
// square root, one after another, in the shared divide and square root unit.
`timescale 1ns / 1ps

module ucb1_arm_selector_top #(
    parameter int MAX_ARMS   = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // tdata: arm_index[3:0], won[4], load_wins[20:5], load_losses[36:21]
    input  logic [39:0]                    s_tdata,
    // tuser: req_type[1:0]
    input  logic [1:0]                     s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata: chosen_arm[3:0], all_tried[4], no_arms[5]
    output logic [7:0]                     m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ucb1_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [16:0]                    cfg_data
);

    localparam int AB   = $clog2(MAX_ARMS);
    localparam int NW   = ($clog2(MAX_ARMS + 1) > 5) ? $clog2(MAX_ARMS + 1) : 5;
    localparam int TW   = COUNT_BITS + 1;
    localparam int TOTW = TW + AB;
    localparam int KW   = $clog2(TOTW);
    localparam int L2W  = KW + 16;
    localparam int DW   = ((COUNT_BITS > L2W) ? COUNT_BITS : L2W) + 16;
    localparam int SW   = DW + 16 + (DW % 2);
    localparam int RTW  = SW / 2;
    localparam int PW   = RTW + 17;
    localparam int UW   = RTW + 2;
    localparam int MW   = 2 * COUNT_BITS;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_REC_WAIT = 4'd1;
    localparam logic [3:0] S_REC_MOD  = 4'd2;
    localparam logic [3:0] S_SCAN     = 4'd3;
    localparam logic [3:0] S_NORM     = 4'd4;
    localparam logic [3:0] S_LOG      = 4'd5;
    localparam logic [3:0] S_LN       = 4'd6;
    localparam logic [3:0] S_P2_WAIT  = 4'd7;
    localparam logic [3:0] S_P2_DATA  = 4'd8;
    localparam logic [3:0] S_MEAN     = 4'd9;
    localparam logic [3:0] S_RATIO    = 4'd10;
    localparam logic [3:0] S_ROOT     = 4'd11;
    localparam logic [3:0] S_CMP      = 4'd12;
    localparam logic [3:0] S_OUT      = 4'd13;

    logic [MW-1:0]   mem [MAX_ARMS];
    logic [MAX_ARMS-1:0] vld_reg;
    logic [MW-1:0]   rdata_reg;
    logic            rvld_reg;
    logic            mem_we;
    logic [AB-1:0]   mem_waddr;
    logic [MW-1:0]   mem_wdata;

    logic [3:0]      state_reg, state_next;
    logic [4:0]      arm_count_reg;
    logic [16:0]     explore_reg;
    logic [AB-1:0]   last_reg, last_next;
    logic [AB-1:0]   rd_addr_reg, rd_addr_next;
    logic            scan_v_reg, scan_v_next;
    logic            data_v_reg, data_v_next;
    logic [AB-1:0]   data_idx_reg, data_idx_next;
    logic            found_reg, found_next;
    logic [AB-1:0]   first_reg, first_next;
    logic [TOTW-1:0] total_reg, total_next;
    logic [TOTW-1:0] norm_reg, norm_next;
    logic [KW-1:0]   shift_reg, shift_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [16:0]     m_reg, m_next;
    logic [15:0]     frac_reg, frac_next;
    logic [3:0]      round_reg, round_next;
    logic [L2W-1:0]  ln_reg, ln_next;
    logic [TW-1:0]   t_reg, t_next;
    logic [16:0]     mean_reg, mean_next;
    logic [PW-1:0]   prod_reg, prod_next;
    logic [UW-1:0]   best_reg, best_next;
    logic [AB-1:0]   best_idx_reg, best_idx_next;
    logic            rec_won_reg, rec_won_next;
    logic [AB-1:0]   res_arm_reg, res_arm_next;
    logic            res_all_reg, res_all_next;
    logic            m_valid_reg;
    logic [7:0]      m_data_reg;

    ucb1_pkg::unit_ctl_t unit_ctl;
    logic [SW-1:0]   unit_a;
    logic [TW-1:0]   unit_b;
    logic            unit_done;
    logic [DW-1:0]   unit_quo;
    logic [RTW-1:0]  unit_root;

    logic [NW-1:0]   n_arms;
    logic [MW-1:0]   eff;
    logic [COUNT_BITS-1:0] cur_w, cur_l;
    logic [TW-1:0]   cur_t;
    logic            is_last;
    logic [33:0]     sq;
    logic [L2W+15:0] ln_prod;
    logic [UW-1:0]   ucb;
    logic [TOTW+16:0] norm_ext;
    logic            out_load;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign out_load  = (state_reg == S_OUT) && (!m_valid_reg || m_tready);

    ucb1_iter_unit #(
        .DW(DW),
        .VW(TW),
        .SW(SW)
    ) u_unit (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctl    (unit_ctl),
        .a_in   (unit_a),
        .b_in   (unit_b),
        .done   (unit_done),
        .quo    (unit_quo),
        .root   (unit_root)
    );

    always_comb begin
        n_arms  = (NW'(arm_count_reg) > NW'(MAX_ARMS)) ? NW'(MAX_ARMS) : NW'(arm_count_reg);
        eff     = rvld_reg ? rdata_reg : '0;
        cur_w   = eff[COUNT_BITS-1:0];
        cur_l   = eff[MW-1:COUNT_BITS];
        cur_t   = {1'b0, cur_w} + {1'b0, cur_l};
        is_last = (NW'(rd_addr_reg) + NW'(1)) == n_arms;
        sq      = m_reg * m_reg;
        ln_prod = {k_reg, frac_reg} * (L2W+16)'(ucb1_pkg::LN2_Q16);
        ucb     = UW'(mean_reg) + UW'(prod_reg[PW-1:16]);
        norm_ext = {norm_reg, 17'd0};

        state_next    = state_reg;
        last_next     = last_reg;
        rd_addr_next  = rd_addr_reg;
        scan_v_next   = scan_v_reg;
        data_v_next   = scan_v_reg;
        data_idx_next = rd_addr_reg;
        found_next    = found_reg;
        first_next    = first_reg;
        total_next    = total_reg;
        norm_next     = norm_reg;
        shift_next    = shift_reg;
        k_next        = k_reg;
        m_next        = m_reg;
        frac_next     = frac_reg;
        round_next    = round_reg;
        ln_next       = ln_reg;
        t_next        = t_reg;
        mean_next     = mean_reg;
        prod_next     = prod_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        rec_won_next  = rec_won_reg;
        res_arm_next  = res_arm_reg;
        res_all_next  = res_all_reg;
        unit_ctl      = '0;
        unit_a        = '0;
        unit_b        = t_reg;
        mem_we        = 1'b0;
        mem_waddr     = last_reg;
        mem_wdata     = eff;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    res_arm_next = last_reg;
                    res_all_next = 1'b0;
                    state_next   = S_OUT;
                    unique case (s_tuser)
                        ucb1_pkg::REQ_SELECT: begin
                            if (n_arms == '0) begin
                                res_arm_next = '0;
                            end else begin
                                rd_addr_next = '0;
                                scan_v_next  = 1'b1;
                                found_next   = 1'b0;
                                total_next   = '0;
                                state_next   = S_SCAN;
                            end
                        end
                        ucb1_pkg::REQ_RECORD: begin
                            rd_addr_next = last_reg;
                            rec_won_next = s_tdata[4];
                            state_next   = S_REC_WAIT;
                        end
                        ucb1_pkg::REQ_LOAD: begin
                            mem_waddr = AB'(s_tdata[3:0]);
                            mem_wdata = {COUNT_BITS'(s_tdata[36:21]),
                                         COUNT_BITS'(s_tdata[20:5])};
                            mem_we    = NW'(s_tdata[3:0]) < NW'(MAX_ARMS);
                        end
                        ucb1_pkg::REQ_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_REC_WAIT: begin
                state_next = S_REC_MOD;
            end
            S_REC_MOD: begin
                mem_we = 1'b1;
                if (rec_won_reg) begin
                    if (cur_w != '1) begin
                        mem_wdata[COUNT_BITS-1:0] = cur_w + COUNT_BITS'(1);
                    end
                end else begin
                    if (cur_l != '1) begin
                        mem_wdata[MW-1:COUNT_BITS] = cur_l + COUNT_BITS'(1);
                    end
                end
                state_next = S_OUT;
            end
            S_SCAN: begin
                if (scan_v_reg) begin
                    if (is_last) begin
                        scan_v_next = 1'b0;
                    end else begin
                        rd_addr_next = rd_addr_reg + AB'(1);
                    end
                end
                if (data_v_reg) begin
                    total_next = total_reg + TOTW'(cur_t);
                    if (cur_t == '0 && !found_reg) begin
                        found_next = 1'b1;
                        first_next = data_idx_reg;
                    end
                end
                if (!scan_v_reg && !data_v_reg) begin
                    if (found_reg) begin
                        res_arm_next = first_reg;
                        last_next    = first_reg;
                        state_next   = S_OUT;
                    end else begin
                        norm_next  = total_reg;
                        shift_next = '0;
                        state_next = S_NORM;
                    end
                end
            end
            S_NORM: begin
                if (norm_reg[TOTW-1]) begin
                    k_next     = KW'(TOTW - 1) - shift_reg;
                    m_next     = norm_ext[TOTW+16 -: 17];
                    frac_next  = '0;
                    round_next = '0;
                    state_next = S_LOG;
                end else begin
                    norm_next  = {norm_reg[TOTW-2:0], 1'b0};
                    shift_next = shift_reg + KW'(1);
                end
            end
            S_LOG: begin
                if (sq[33]) begin
                    m_next = sq[33:17];
                    frac_next[4'd15 - round_reg] = 1'b1;
                end else begin
                    m_next = sq[32:16];
                end
                round_next = round_reg + 4'd1;
                if (round_reg == 4'd15) begin
                    state_next = S_LN;
                end
            end
            S_LN: begin
                ln_next      = ln_prod[L2W+15:16];
                rd_addr_next = '0;
                best_next    = '0;
                state_next   = S_P2_WAIT;
            end
            S_P2_WAIT: begin
                state_next = S_P2_DATA;
            end
            S_P2_DATA: begin
                t_next         = cur_t;
                unit_ctl.start = 1'b1;
                unit_a         = SW'({cur_w, 16'd0});
                unit_b         = cur_t;
                state_next     = S_MEAN;
            end
            S_MEAN: begin
                if (unit_done) begin
                    mean_next      = unit_quo[16:0];
                    unit_ctl.start = 1'b1;
                    unit_a         = SW'({ln_reg, 16'd0});
                    state_next     = S_RATIO;
                end
            end
            S_RATIO: begin
                if (unit_done) begin
                    unit_ctl.start   = 1'b1;
                    unit_ctl.sqrt_op = 1'b1;
                    unit_a           = SW'({unit_quo, 16'd0});
                    state_next       = S_ROOT;
                end
            end
            S_ROOT: begin
                if (unit_done) begin
                    prod_next  = explore_reg * unit_root;
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (rd_addr_reg == '0 || ucb > best_reg) begin
                    best_next     = ucb;
                    best_idx_next = rd_addr_reg;
                end
                if (is_last) begin
                    res_arm_next = best_idx_next;
                    last_next    = best_idx_next;
                    res_all_next = 1'b1;
                    state_next   = S_OUT;
                end else begin
                    rd_addr_next = rd_addr_reg + AB'(1);
                    state_next   = S_P2_WAIT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[rd_addr_reg];
        rvld_reg  <= vld_reg[rd_addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            state_reg     <= S_IDLE;
            arm_count_reg <= '0;
            explore_reg   <= ucb1_pkg::EXPLORE_RESET;
            last_reg      <= '0;
            scan_v_reg    <= 1'b0;
            data_v_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (mem_we) begin
                vld_reg[mem_waddr] <= 1'b1;
            end
            state_reg  <= state_next;
            last_reg   <= last_next;
            scan_v_reg <= scan_v_next;
            data_v_reg <= data_v_next;
            if (cfg_valid) begin
                if (cfg_index == ucb1_pkg::CFG_ARM_COUNT) begin
                    arm_count_reg <= cfg_data[4:0];
                end else if (cfg_index == ucb1_pkg::CFG_EXPLORE) begin
                    explore_reg <= cfg_data;
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg  <= rd_addr_next;
        data_idx_reg <= data_idx_next;
        found_reg    <= found_next;
        first_reg    <= first_next;
        total_reg    <= total_next;
        norm_reg     <= norm_next;
        shift_reg    <= shift_next;
        k_reg        <= k_next;
        m_reg        <= m_next;
        frac_reg     <= frac_next;
        round_reg    <= round_next;
        ln_reg       <= ln_next;
        t_reg        <= t_next;
        mean_reg     <= mean_next;
        prod_reg     <= prod_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        rec_won_reg  <= rec_won_next;
        res_arm_reg  <= res_arm_next;
        res_all_reg  <= res_all_next;
        if (out_load) begin
            m_data_reg <= {2'b00, (arm_count_reg == 5'd0), res_all_reg, 4'(res_arm_reg)};
        end
    end

endmodule

/* hw/rtl/ucb1_checker.sv */
// ----------------------------------------------------------------------------
// ucb1_checker
// Port-level checks of the UCB1 arm selector, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ucb1_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] m_tdata,
    input logic       m_tvalid,
    input logic       m_tready
);

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))
    `ASSERT_IMPLY(a_no_arms_no_ucb, aclk, aresetn, m_tvalid && m_tdata[5], !m_tdata[4])
    `ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

bind ucb1_arm_selector_top ucb1_checker u_ucb1_checker (.*);
